// File: design/rasm_pkg.sv
package rasm_pkg;

    localparam int DEFAULT_WINDOW = 50;
    localparam int DEFAULT_BATCH  = 50;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int SUM_W    = 23;
    localparam int LEVEL_W  = 24;
    localparam int THR_W    = 16;
    localparam int CFG_W    = 23;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 3;

    localparam logic [THR_W-1:0] SPIKE_THR_RESET = THR_W'(3000);
    localparam logic [SUM_W-1:0] LOW_SUM_RESET   = SUM_W'(500000);
    localparam logic [SUM_W-1:0] LEVEL_DELTA_RESET = SUM_W'(10000);

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPIKE_THR   = 2'd0,
        REG_LOW_SUM     = 2'd1,
        REG_LEVEL_DELTA = 2'd2
    } cfg_reg_t;

    // what one ring cell is told to do
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic [SUM_W-1:0] window_sum;
        logic             spike;
        logic             level_changed;
        logic             restart_request;
    } result_t;

endpackage

// File: design/rasm_cell.sv
module rasm_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rasm_pkg::cell_ctrl_t        ctrl,
    input  logic [rasm_pkg::MAG_W-1:0]  mag_in,
    output logic [rasm_pkg::MAG_W-1:0]  mag_out
);

    logic [rasm_pkg::MAG_W-1:0] mag_reg;
    logic [rasm_pkg::MAG_W-1:0] mag_next;

    always_comb begin
        mag_next = mag_reg;
        if (ctrl.clear) begin
            mag_next = '0;
        end else if (ctrl.shift) begin
            mag_next = mag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg <= '0;
        end else begin
            mag_reg <= mag_next;
        end
    end

    assign mag_out = mag_reg;

endmodule

// File: design/rasm_skid.sv
module rasm_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rasm_pkg::result_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rasm_pkg::result_t   out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    rasm_pkg::result_t out_data_reg, out_data_next;
    rasm_pkg::result_t skid_data_reg, skid_data_next;
    logic              take;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = take;
                out_data_next  = in_data;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/rolling_abs_sum_spike_monitor.sv
// Throughput: one item per cycle while s_tready is high; each result is registered
// in the output stage. The magnitude ring is a row of WINDOW cells that shifts
// once per sample, so the running sum is one subtract and one add per item.
// A two-deep output stage keeps s_tready high while one result waits on m_tready.
// Reset (aresetn low, synchronous) clears the ring, the sum, the counters, the
// previous sample and the level, and loads the registers with their defaults.
module rolling_abs_sum_spike_monitor #(
    parameter int WINDOW = rasm_pkg::DEFAULT_WINDOW,
    parameter int BATCH  = rasm_pkg::DEFAULT_BATCH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [rasm_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [rasm_pkg::CFG_W-1:0]       cfg_wr_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rasm_pkg::S_DATA_W-1:0]    s_tdata,   // [15:0] sample
    input  logic                             s_tuser,   // [0] cmd
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rasm_pkg::M_DATA_W-1:0]    m_tdata,   // [22:0] window_sum, [23] zero
    output logic [rasm_pkg::M_USER_W-1:0]    m_tuser    // [0] spike, [1] level_changed,
                                                        // [2] restart_request
);

    localparam int POS_W = (BATCH > 1) ? $clog2(BATCH) : 1;
    localparam logic [POS_W-1:0] BATCH_LAST = POS_W'(BATCH - 1);
    localparam int DIFF_W = rasm_pkg::SAMPLE_W + 1;
    localparam int LDIFF_W = rasm_pkg::LEVEL_W + 1;
    localparam logic signed [rasm_pkg::LEVEL_W-1:0] WINDOW_S = rasm_pkg::LEVEL_W'(WINDOW);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rasm_pkg::THR_W-1:0] spike_thr_reg, spike_thr_next;
    logic [rasm_pkg::SUM_W-1:0] low_sum_reg, low_sum_next;
    logic [rasm_pkg::SUM_W-1:0] level_delta_reg, level_delta_next;

    always_comb begin
        spike_thr_next   = spike_thr_reg;
        low_sum_next     = low_sum_reg;
        level_delta_next = level_delta_reg;
        if (cfg_wr_en) begin
            unique case (rasm_pkg::cfg_reg_t'(cfg_addr))
                rasm_pkg::REG_SPIKE_THR: begin
                    spike_thr_next = cfg_wr_data[rasm_pkg::THR_W-1:0];
                end
                rasm_pkg::REG_LOW_SUM: begin
                    low_sum_next = cfg_wr_data;
                end
                rasm_pkg::REG_LEVEL_DELTA: begin
                    level_delta_next = cfg_wr_data;
                end
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spike_thr_reg   <= rasm_pkg::SPIKE_THR_RESET;
            low_sum_reg     <= rasm_pkg::LOW_SUM_RESET;
            level_delta_reg <= rasm_pkg::LEVEL_DELTA_RESET;
        end else begin
            spike_thr_reg   <= spike_thr_next;
            low_sum_reg     <= low_sum_next;
            level_delta_reg <= level_delta_next;
        end
    end

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    logic                                  accept;
    logic                                  ready_int;
    logic                                  is_restart_cmd;
    logic signed [rasm_pkg::SAMPLE_W-1:0]  sample;
    logic [rasm_pkg::MAG_W-1:0]            mag;

    assign s_tready       = ready_int;
    assign accept         = s_tvalid && ready_int;
    assign is_restart_cmd = s_tuser;
    assign sample         = $signed(s_tdata);

    // Magnitude, saturate the most negative sample at full scale
    always_comb begin
        if (!sample[rasm_pkg::SAMPLE_W-1]) begin
            mag = sample[rasm_pkg::MAG_W-1:0];
        end else if (sample[rasm_pkg::MAG_W-1:0] == '0) begin
            mag = rasm_pkg::MAG_MAX;
        end else begin
            mag = rasm_pkg::MAG_W'(-sample);
        end
    end

    // ------------------------------------------------------------------
    // Magnitude ring: a row of cells, oldest magnitude at the far end
    // ------------------------------------------------------------------
    rasm_pkg::cell_ctrl_t        cell_ctrl;
    logic [rasm_pkg::MAG_W-1:0]  ring_tap [WINDOW];
    logic [rasm_pkg::MAG_W-1:0]  oldest;

    assign oldest = ring_tap[WINDOW-1];

    for (genvar i = 0; i < WINDOW; i++) begin : g_ring
        if (i == 0) begin : g_head
            rasm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .mag_in  (mag),
                .mag_out (ring_tap[i])
            );
        end else begin : g_body
            rasm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .mag_in  (ring_tap[i-1]),
                .mag_out (ring_tap[i])
            );
        end
    end

    // ------------------------------------------------------------------
    // Window state
    // ------------------------------------------------------------------
    logic [rasm_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic [POS_W-1:0]                     pos_reg, pos_next;
    logic signed [rasm_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic signed [rasm_pkg::LEVEL_W-1:0]  level_reg, level_next;

    logic [rasm_pkg::SUM_W-1:0]           sum_upd;
    logic signed [DIFF_W-1:0]             diff;
    logic [DIFF_W-1:0]                    adiff;
    logic signed [LDIFF_W-1:0]            ldiff;
    logic [LDIFF_W-1:0]                   aldiff;
    logic                                 batch_end;
    logic                                 spike;
    logic                                 changed;
    logic                                 low_sum;
    logic signed [rasm_pkg::LEVEL_W-1:0]  ref_level;
    rasm_pkg::result_t                    result;

    // Drop the oldest magnitude and add the new one; wraps like the 23-bit sum
    assign sum_upd = sum_reg - rasm_pkg::SUM_W'(oldest) + rasm_pkg::SUM_W'(mag);

    assign diff  = DIFF_W'(sample) - DIFF_W'(prev_reg);
    assign adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    assign ldiff  = LDIFF_W'(level_reg) - $signed({2'b00, sum_upd});
    assign aldiff = ldiff[LDIFF_W-1] ? LDIFF_W'(-ldiff) : LDIFF_W'(ldiff);

    assign batch_end = (pos_reg == BATCH_LAST);
    assign spike     = (pos_reg != '0) && (adiff > DIFF_W'(spike_thr_reg));
    assign changed   = batch_end && (aldiff > LDIFF_W'(level_delta_reg));
    assign low_sum   = batch_end && (sum_upd < low_sum_reg);

    // Restart level: reference sample scaled by the window length
    assign ref_level = rasm_pkg::LEVEL_W'(rasm_pkg::LEVEL_W'(sample) * WINDOW_S);

    always_comb begin
        sum_next   = sum_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        level_next = level_reg;
        cell_ctrl  = '0;
        result     = '0;
        if (accept) begin
            if (is_restart_cmd) begin
                // load the level, clear the window
                sum_next        = '0;
                pos_next        = '0;
                prev_next       = '0;
                level_next      = ref_level;
                cell_ctrl.clear = 1'b1;
            end else begin
                sum_next        = sum_upd;
                pos_next        = batch_end ? '0 : pos_reg + 1'b1;
                prev_next       = sample;
                cell_ctrl.shift = 1'b1;
                if (changed) begin
                    level_next = $signed({1'b0, sum_upd});
                end
                if (low_sum) begin
                    // sum fell too low: clear the window and ask for a new axis
                    sum_next        = '0;
                    prev_next       = '0;
                    cell_ctrl.clear = 1'b1;
                end
                result.window_sum      = low_sum ? '0 : sum_upd;
                result.spike           = spike;
                result.level_changed   = changed;
                result.restart_request = low_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            pos_reg   <= '0;
            prev_reg  <= '0;
            level_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            level_reg <= level_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    rasm_pkg::result_t out_data;

    rasm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (ready_int),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0, out_data.window_sum};
    assign m_tuser = {out_data.restart_request, out_data.level_changed, out_data.spike};

endmodule

// File: design/rasm_checker.sv
module rasm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rasm_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [rasm_pkg::M_USER_W-1:0]  m_tuser
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a restart request reports an empty window
    a_restart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata == '0)
        else $error("restart request with nonzero sum");

    // with no result pending the spare stage is empty, so input is taken
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

endmodule

bind rolling_abs_sum_spike_monitor rasm_checker u_rasm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: test/rolling_abs_sum_spike_monitor_tb.sv
`timescale 1ns / 100ps

module rolling_abs_sum_spike_monitor_tb;

    import rasm_pkg::*;

    localparam int WIN = DEFAULT_WINDOW;
    localparam int BAT = DEFAULT_BATCH;
    localparam int SUM_MASK = (1 << SUM_W) - 1;
    localparam int THR_MASK = (1 << THR_W) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;
    // index past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic              cmd;
        logic [SAMPLE_W-1:0] smp;
    } sample_item_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;   // [15:0] sample
    logic                  s_tuser     = 1'b0; // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;            // [22:0] window_sum, [23] zero
    logic [M_USER_W-1:0]   m_tuser;            // [0] spike, [1] level_changed,
                                               // [2] restart_request

    rolling_abs_sum_spike_monitor dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the monitor state and its registers
    // ------------------------------------------------------------------
    int mag_ring [WIN];
    int sum_acc;
    int slot_ptr;
    int batch_cnt;
    int prev_smp;
    int level_ref;
    int thr_spike;
    int thr_low;
    int thr_delta;

    function automatic void clear_window_state();
        for (int i = 0; i < WIN; i++) mag_ring[i] = 0;
        sum_acc   = 0;
        slot_ptr  = 0;
        batch_cnt = 0;
        prev_smp  = 0;
    endfunction

    // Advance the shadow state by one item and return the result it causes.
    function automatic result_t predict_window(logic cmd, logic [SAMPLE_W-1:0] raw);
        int s;
        int mag;
        int ptr;
        int diff;
        int dev;
        result_t r;
        r = '0;
        s = $signed(raw);
        if (cmd) begin
            // restart: level comes from the reference sample, window is emptied
            level_ref = s * WIN;
            clear_window_state();
        end else begin
            mag = (s < 0) ? -s : s;
            if (mag > int'(MAG_MAX)) mag = int'(MAG_MAX);
            ptr = (slot_ptr < WIN) ? slot_ptr : 0;
            sum_acc = (sum_acc - mag_ring[ptr] + mag) & SUM_MASK;
            mag_ring[ptr] = mag;
            slot_ptr = (ptr + 1 >= WIN) ? 0 : ptr + 1;

            // no spike check on the first sample of a batch
            diff = s - prev_smp;
            if (diff < 0) diff = -diff;
            if (batch_cnt > 0 && diff > thr_spike) r.spike = 1'b1;
            prev_smp = s;

            batch_cnt++;
            if (batch_cnt >= BAT) begin
                batch_cnt = 0;
                dev = level_ref - sum_acc;
                if (dev < 0) dev = -dev;
                if (dev > thr_delta) begin
                    r.level_changed = 1'b1;
                    level_ref = sum_acc;
                end
                if (sum_acc < thr_low) begin
                    r.restart_request = 1'b1;
                    clear_window_state();
                end
            end
        end
        r.window_sum = SUM_W'(sum_acc);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping shared by driver, monitor and sequencer
    // ------------------------------------------------------------------
    sample_item_t pending_items [$];
    result_t      expected_results [$];
    int items_queued  = 0;
    int items_taken   = 0;
    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_cnt < PRINT_LIMIT)
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Driver: present pending items with random gaps between them
    // ------------------------------------------------------------------
    int  drv_gap  = 0;
    bit  drv_calm = 1'b0;

    always @(posedge aclk) begin
        sample_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // record the item that the block takes at this edge
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_window(s_tuser, s_tdata));
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.smp;
                    s_tuser  <= it.cmd;
                    // occasionally switch between back-to-back and gappy traffic
                    if ($urandom_range(0, 99) < 3) drv_calm = ~drv_calm;
                    drv_gap = drv_calm ? 0 : $urandom_range(0, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random and compare each result with the oldest
    // expectation
    // ------------------------------------------------------------------
    int  mon_stall = 0;
    bit  mon_calm  = 1'b0;

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", int'(m_tdata), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want.window_sum)
                        report_mismatch("window_sum", int'(m_tdata[SUM_W-1:0]),
                                        int'(want.window_sum));
                    if (m_tdata[M_DATA_W-1:SUM_W] !== '0)
                        report_mismatch("tdata pad", int'(m_tdata[M_DATA_W-1:SUM_W]), 0);
                    if (m_tuser[0] !== want.spike)
                        report_mismatch("spike", int'(m_tuser[0]), int'(want.spike));
                    if (m_tuser[1] !== want.level_changed)
                        report_mismatch("level_changed", int'(m_tuser[1]),
                                        int'(want.level_changed));
                    if (m_tuser[2] !== want.restart_request)
                        report_mismatch("restart_request", int'(m_tuser[2]),
                                        int'(want.restart_request));
                end
                if ($urandom_range(0, 99) < 3) mon_calm = ~mon_calm;
                mon_stall = mon_calm ? 0 : $urandom_range(0, 5);
            end
            if (mon_stall > 0) begin
                mon_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Abort a run that hangs.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_SPIKE_THR:   thr_spike = int'(val) & THR_MASK;
            REG_LOW_SUM:     thr_low   = int'(val) & SUM_MASK;
            REG_LEVEL_DELTA: thr_delta = int'(val) & SUM_MASK;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        sample_item_t it;
        it.cmd = cmd;
        it.smp = smp;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Hold until every queued item is taken and every result has come back.
    task automatic wait_drained();
        do @(negedge aclk);
        while (items_taken != items_queued || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Fill one phase with random items: mostly loud or quiet runs long enough to
    // reach batch ends, some smooth stretches, some extremes, rare restarts, noise.
    task automatic queue_random(input int count);
        int  r;
        int  v;
        int  last;
        bit  loud;
        loud = $urandom_range(0, 1);
        last = 0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 3) loud = ~loud;
            r = $urandom_range(0, 99);
            if (r < 1) begin
                queue_item(1'b1, SAMPLE_W'($urandom));
                continue;
            end else if (r < 6) begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    default: v = -32767;
                endcase
            end else if (r < 70) begin
                v = loud ? $urandom_range(12000, 32767) : $urandom_range(0, 4000);
                if ($urandom_range(0, 1)) v = -v;
            end else if (r < 90) begin
                v = last + $urandom_range(0, 8000) - 4000;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end else begin
                v = $signed(SAMPLE_W'($urandom));
            end
            last = v;
            queue_item(1'b0, SAMPLE_W'(v));
        end
    endtask

    initial begin
        thr_spike = int'(SPIKE_THR_RESET);
        thr_low   = int'(LOW_SUM_RESET);
        thr_delta = int'(LEVEL_DELTA_RESET);
        level_ref = 0;
        clear_window_state();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, saturation, restart commands, and the
        // first sample after a restart, which must never be flagged
        queue_item(1'b0, 16'h0000);
        queue_item(1'b0, 16'h7FFF);
        queue_item(1'b0, 16'h8000);     // most negative, magnitude saturates
        queue_item(1'b0, 16'h8001);
        queue_item(1'b0, 16'h7FFF);
        queue_item(1'b0, 16'h0001);
        queue_item(1'b0, 16'hFFFF);
        queue_item(1'b0, 16'h0BB8);     // step one above the default threshold
        queue_item(1'b0, 16'h1771);     // one above it
        queue_item(1'b1, 16'h7FFF);     // largest reference level
        queue_item(1'b0, 16'h8000);     // first of batch, huge jump
        queue_item(1'b0, 16'h7FFF);
        queue_item(1'b1, 16'h8000);     // most negative reference level
        queue_item(1'b0, 16'h7FFF);
        queue_item(1'b0, 16'h0000);
        queue_item(1'b1, 16'h0000);
        queue_item(1'b0, 16'h5555);
        queue_item(1'b0, 16'hAAAA);
        wait_drained();

        // Phases: defaults restored with junk in the upper data bits, all minimum, the
        // largest spike threshold with near-full sum thresholds, then two random settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_UNUSED, CFG_W'($urandom));
            case (ph)
                0: begin
                    write_reg(REG_SPIKE_THR, {7'h5A, SPIKE_THR_RESET});
                    write_reg(REG_LOW_SUM, LOW_SUM_RESET);
                    write_reg(REG_LEVEL_DELTA, LEVEL_DELTA_RESET);
                end
                1: begin
                    write_reg(REG_SPIKE_THR, '0);
                    write_reg(REG_LOW_SUM, '0);
                    write_reg(REG_LEVEL_DELTA, '0);
                end
                2: begin
                    write_reg(REG_SPIKE_THR, CFG_W'(65535));
                    write_reg(REG_LOW_SUM, CFG_W'(8388352));
                    write_reg(REG_LEVEL_DELTA, CFG_W'(8388352));
                end
                default: begin
                    write_reg(REG_SPIKE_THR,
                              {CFG_W'($urandom) & ~CFG_W'(THR_MASK)}
                              | CFG_W'($urandom_range(0, 40000)));
                    write_reg(REG_LOW_SUM, CFG_W'($urandom_range(0, 1200000)));
                    write_reg(REG_LEVEL_DELTA, CFG_W'($urandom_range(0, 400000)));
                end
            endcase
            queue_random(107);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
design/rasm_pkg.sv
design/rasm_cell.sv
design/rasm_skid.sv
design/rolling_abs_sum_spike_monitor.sv
design/rasm_checker.sv
test/rolling_abs_sum_spike_monitor_tb.sv
